// ----- hw/rtl/assert_macros.svh -----
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, skipped while in reset
`define PKI_ASSERT_NOW(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("pki assertion failed");

// next-cycle implication, skipped while in reset
`define PKI_ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("pki assertion failed");

`endif

// ----- hw/rtl/pki_pkg.sv -----
package pki_pkg;

  // channel and step limits
  localparam int CHANNELS    = 17;
  localparam int CH_W        = 5;
  localparam int CH_IDX_W    = $clog2(CHANNELS);
  localparam int POS_W       = 16;
  localparam int STEP_W      = 4;
  localparam int DIV_W       = STEP_W + 1;
  localparam int DIV_CNT_W   = $clog2(POS_W);
  localparam logic [STEP_W-1:0] MAX_STEPS = STEP_W'(15);

  // stream packing
  localparam int TDATA_W     = 32;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // one classified keyframe request handed from front to back
  typedef struct packed {
    logic [CH_W-1:0]   channel;
    logic [POS_W-1:0]  prev;
    logic [POS_W-1:0]  target;
    logic [POS_W-1:0]  diff;
    logic              rising;
    logic [STEP_W-1:0] steps;
  } cmd_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_EMIT
  } back_state_t;

endpackage

// ----- hw/rtl/pki_front.sv -----
module pki_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [pki_pkg::CH_W-1:0]     channel,
  input  logic [pki_pkg::POS_W-1:0]    position,
  input  logic [pki_pkg::STEP_W-1:0]   inserted_steps,
  output logic                         push_valid,
  input  logic                         push_ready,
  output pki_pkg::cmd_t                push_cmd
);

  logic [pki_pkg::CHANNELS-1:0] seen;
  logic [pki_pkg::POS_W-1:0]    prev_pose [pki_pkg::CHANNELS];

  logic                         in_range;
  logic                         accept;
  logic [pki_pkg::CH_IDX_W-1:0] idx;
  logic [pki_pkg::POS_W-1:0]    prev;
  logic [pki_pkg::STEP_W-1:0]   steps_sat;

  // classify the request
  assign in_range = channel < pki_pkg::CH_W'(pki_pkg::CHANNELS);
  assign idx      = channel[pki_pkg::CH_IDX_W-1:0];
  assign in_ready = push_ready;
  assign accept   = in_valid && push_ready && in_range;
  assign prev     = prev_pose[idx];
  assign steps_sat = (inserted_steps > pki_pkg::MAX_STEPS) ? pki_pkg::MAX_STEPS
                                                           : inserted_steps;

  // build the command for the back end
  always_comb begin
    push_valid       = in_valid && in_range;
    push_cmd.channel = channel;
    push_cmd.target  = position;
    if (!seen[idx]) begin
      // first keyframe on the channel passes straight through
      push_cmd.prev   = position;
      push_cmd.diff   = '0;
      push_cmd.rising = 1'b1;
      push_cmd.steps  = '0;
    end else begin
      push_cmd.prev   = prev;
      push_cmd.rising = position >= prev;
      push_cmd.diff   = (position >= prev) ? (position - prev) : (prev - position);
      push_cmd.steps  = steps_sat;
    end
  end

  // seen flags
  always_ff @(posedge clk) begin
    if (rst) begin
      seen <= '0;
    end else if (accept) begin
      seen[idx] <= 1'b1;
    end
  end

  // last keyframe per channel
  always_ff @(posedge clk) begin
    if (accept) begin
      prev_pose[idx] <= position;
    end
  end

endmodule

// ----- hw/rtl/pki_queue.sv -----
module pki_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push_valid,
  output logic          push_ready,
  input  pki_pkg::cmd_t push_cmd,
  output logic          pop_valid,
  input  logic          pop_ready,
  output pki_pkg::cmd_t pop_cmd
);

  pki_pkg::cmd_t                slots [pki_pkg::QUEUE_DEPTH];
  logic [pki_pkg::QPTR_W-1:0]   wr_ptr;
  logic [pki_pkg::QPTR_W-1:0]   rd_ptr;
  logic [pki_pkg::QPTR_W:0]     count;
  logic                         do_push;
  logic                         do_pop;

  assign push_ready = count != (pki_pkg::QPTR_W+1)'(pki_pkg::QUEUE_DEPTH);
  assign pop_valid  = count != '0;
  assign pop_cmd    = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  // slot storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

endmodule

// ----- hw/rtl/pki_back.sv -----
module pki_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        pop_valid,
  output logic                        pop_ready,
  input  pki_pkg::cmd_t               pop_cmd,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [pki_pkg::CH_W-1:0]    out_channel,
  output logic [pki_pkg::STEP_W-1:0]  step_index,
  output logic [pki_pkg::POS_W-1:0]   out_position,
  output logic                        last
);

  pki_pkg::back_state_t state;
  pki_pkg::back_state_t state_next;
  pki_pkg::cmd_t        cmd;

  logic [pki_pkg::POS_W-1:0]     quo;
  logic [pki_pkg::DIV_W-1:0]     rem;
  logic [pki_pkg::DIV_CNT_W-1:0] cnt;
  logic [pki_pkg::POS_W-1:0]     acc_q;
  logic [pki_pkg::DIV_W-1:0]     acc_r;
  logic [pki_pkg::STEP_W-1:0]    step;

  logic [pki_pkg::DIV_W-1:0]     divisor;
  logic [pki_pkg::DIV_W-1:0]     rem_sh;
  logic                          rem_ge;
  logic [pki_pkg::DIV_W-1:0]     rem_next;
  logic [pki_pkg::POS_W-1:0]     quo_next;
  logic [pki_pkg::DIV_W-1:0]     sum_r;
  logic                          sum_ge;
  logic                          final_step;
  logic                          out_load;
  logic [pki_pkg::POS_W-1:0]     pos_calc;

  // divisor is steps + 1
  assign divisor = {1'b0, cmd.steps} + 1'b1;

  // one restoring-division bit per cycle
  assign rem_sh   = {rem[pki_pkg::DIV_W-2:0], quo[pki_pkg::POS_W-1]};
  assign rem_ge   = rem_sh >= divisor;
  assign rem_next = rem_ge ? (rem_sh - divisor) : rem_sh;
  assign quo_next = {quo[pki_pkg::POS_W-2:0], rem_ge};

  // running remainder of (step+1)*diff/(steps+1)
  assign sum_r  = acc_r + rem;
  assign sum_ge = sum_r >= divisor;

  assign final_step = step == cmd.steps;
  assign pos_calc   = final_step  ? cmd.target :
                      cmd.rising  ? (cmd.prev + acc_q) : (cmd.prev - acc_q);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      pki_pkg::BK_IDLE: begin
        if (pop_valid) begin
          state_next = (pop_cmd.steps == '0) ? pki_pkg::BK_EMIT : pki_pkg::BK_DIV;
        end
      end
      pki_pkg::BK_DIV: begin
        if (cnt == '1) state_next = pki_pkg::BK_EMIT;
      end
      pki_pkg::BK_EMIT: begin
        if (out_load && final_step) state_next = pki_pkg::BK_IDLE;
      end
      default: state_next = pki_pkg::BK_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    pop_ready = 1'b0;
    out_load  = 1'b0;
    case (state)
      pki_pkg::BK_IDLE: pop_ready = 1'b1;
      pki_pkg::BK_EMIT: out_load  = !out_valid || out_ready;
      default: begin
        pop_ready = 1'b0;
        out_load  = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pki_pkg::BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // divider and step datapath
  always_ff @(posedge clk) begin
    if (state == pki_pkg::BK_IDLE && pop_valid) begin
      cmd  <= pop_cmd;
      quo  <= pop_cmd.diff;
      rem  <= '0;
      cnt  <= '0;
      step <= '0;
    end else if (state == pki_pkg::BK_DIV) begin
      quo <= quo_next;
      rem <= rem_next;
      cnt <= cnt + 1'b1;
      if (cnt == '1) begin
        acc_q <= quo_next;
        acc_r <= rem_next;
      end
    end else if (out_load) begin
      step <= step + 1'b1;
      if (sum_ge) begin
        acc_r <= sum_r - divisor;
        acc_q <= acc_q + quo + 1'b1;
      end else begin
        acc_r <= sum_r;
        acc_q <= acc_q + quo;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_channel  <= cmd.channel;
      step_index   <= step;
      out_position <= pos_calc;
      last         <= final_step;
    end
  end

endmodule

// ----- hw/rtl/pose_keyframe_interpolator_top.sv -----
// Per-channel linear keyframe interpolator.
// Input stream (s_*): one request per keyframe carrying channel, position and
// the count n of positions to insert. Channels at or above 17 are dropped.
// Output stream (m_*): the first keyframe on a channel gives one result; later
// keyframes give n interpolated positions then the keyframe itself, tlast set
// on the keyframe. Each result carries channel and its step index.
// Flow: an accepted request is written into the queue and popped by the back
// end when it is idle; with n > 0 a shared bit-serial divider runs first, then
// one result per cycle while the receiver takes them; with n = 0 or on a first
// keyframe no divide runs. No new request is popped until the run has ended.
// A two-entry request queue lets the front keep accepting while results drain.
// Reset clears the seen flags, the queue and the output valid; stored
// positions are only read once a channel has been seen.
// When m_tready is low the output register holds its result and the back end
// waits; the front stops accepting once the queue is full.
module pose_keyframe_interpolator_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // channel[4:0], position[20:5], inserted_steps[24:21], zero above
  input  logic [pki_pkg::TDATA_W-1:0]   s_tdata,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // out_channel[4:0], step_index[8:5], out_position[24:9], zero above
  output logic [pki_pkg::TDATA_W-1:0]   m_tdata,
  output logic                          m_tlast
);

  localparam int IN_USED  = pki_pkg::CH_W + pki_pkg::POS_W + pki_pkg::STEP_W;
  localparam int OUT_USED = pki_pkg::CH_W + pki_pkg::STEP_W + pki_pkg::POS_W;

  logic                          push_valid;
  logic                          push_ready;
  pki_pkg::cmd_t                 push_cmd;
  logic                          pop_valid;
  logic                          pop_ready;
  pki_pkg::cmd_t                 pop_cmd;
  logic [pki_pkg::CH_W-1:0]      out_channel;
  logic [pki_pkg::STEP_W-1:0]    step_index;
  logic [pki_pkg::POS_W-1:0]     out_position;

  // front: classify and track channel state
  pki_front u_front (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (s_tvalid),
    .in_ready       (s_tready),
    .channel        (s_tdata[pki_pkg::CH_W-1:0]),
    .position       (s_tdata[pki_pkg::CH_W +: pki_pkg::POS_W]),
    .inserted_steps (s_tdata[pki_pkg::CH_W + pki_pkg::POS_W +: pki_pkg::STEP_W]),
    .push_valid     (push_valid),
    .push_ready     (push_ready),
    .push_cmd       (push_cmd)
  );

  // request queue
  pki_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_cmd    (pop_cmd)
  );

  // back: divide and emit the run
  pki_back u_back (
    .clk          (clk),
    .rst          (rst),
    .pop_valid    (pop_valid),
    .pop_ready    (pop_ready),
    .pop_cmd      (pop_cmd),
    .out_valid    (m_tvalid),
    .out_ready    (m_tready),
    .out_channel  (out_channel),
    .step_index   (step_index),
    .out_position (out_position),
    .last         (m_tlast)
  );

  // pack the result
  assign m_tdata = {{(pki_pkg::TDATA_W-OUT_USED){1'b0}}, out_position, step_index,
                    out_channel};

  // upper input bits are padding
  logic unused_in;
  assign unused_in = ^s_tdata[pki_pkg::TDATA_W-1:IN_USED];

endmodule

// ----- hw/rtl/pki_checker.sv -----
`include "assert_macros.svh"

module pki_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        s_tvalid,
  input logic                        s_tready,
  input logic [pki_pkg::TDATA_W-1:0] s_tdata,
  input logic                        m_tvalid,
  input logic                        m_tready,
  input logic [pki_pkg::TDATA_W-1:0] m_tdata,
  input logic                        m_tlast
);

  // a stalled result holds
  `PKI_ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast))

  // nothing shows right after reset
  `PKI_ASSERT_NOW(a_reset_quiet, clk, rst, $past(rst), !m_tvalid)

  // results only on channels in range, padding zero
  `PKI_ASSERT_NOW(a_out_channel, clk, rst, m_tvalid, (m_tdata[4:0] < pki_pkg::CH_W'(pki_pkg::CHANNELS)) && (m_tdata[31:25] == '0))

  // an inserted position never has the top step index
  `PKI_ASSERT_NOW(a_inserted_index, clk, rst, m_tvalid && !m_tlast, m_tdata[8:5] != pki_pkg::MAX_STEPS)

  logic unused_in;
  assign unused_in = s_tvalid ^ s_tready ^ (^s_tdata);

endmodule

bind pose_keyframe_interpolator_top pki_checker u_pki_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

// ----- dv/testbench.sv -----
module testbench;
  import pki_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 40;
  localparam int RANDOM_ITEMS   = 456;

  // one keyframe request as it goes into the block
  typedef struct {
    logic [CH_W-1:0]   channel;
    logic [POS_W-1:0]  position;
    logic [STEP_W-1:0] steps;
  } keyframe_t;

  // one emitted pose as it comes out of the block
  typedef struct {
    logic [CH_W-1:0]   channel;
    logic [STEP_W-1:0] step_index;
    logic [POS_W-1:0]  position;
    logic              last;
  } pose_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  // channel[4:0], position[20:5], inserted_steps[24:21], zero above
  logic [TDATA_W-1:0]  s_tdata = '0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  // out_channel[4:0], step_index[8:5], out_position[24:9], zero above
  logic [TDATA_W-1:0]  m_tdata;
  logic                m_tlast;

  keyframe_t           keyframes_pending[$];
  pose_t               poses_expected[$];
  logic [POS_W-1:0]    last_keyframe[CHANNELS];
  logic                channel_started[CHANNELS];
  int                  keyframes_total = 0;
  int                  keyframes_taken = 0;
  int                  poses_taken = 0;
  int                  mismatches = 0;

  pose_keyframe_interpolator_top dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  // clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // expected poses for one accepted keyframe
  function automatic void interpolate_keyframe(input keyframe_t kf);
    int    n;
    int    from;
    int    span;
    int    delta;
    pose_t p;
    if (kf.channel >= CHANNELS) return;
    p.channel = kf.channel;
    if (!channel_started[kf.channel]) begin
      // first keyframe on a channel passes straight through
      p.step_index = '0;
      p.position   = kf.position;
      p.last       = 1'b1;
      poses_expected.push_back(p);
      last_keyframe[kf.channel]   = kf.position;
      channel_started[kf.channel] = 1'b1;
      return;
    end
    n = (kf.steps > MAX_STEPS) ? int'(MAX_STEPS) : int'(kf.steps);
    from = int'(last_keyframe[kf.channel]);
    span = (int'(kf.position) >= from) ? int'(kf.position) - from : from - int'(kf.position);
    for (int s = 0; s < n; s++) begin
      delta        = ((s + 1) * span) / (n + 1);
      p.step_index = STEP_W'(s);
      p.position   = (int'(kf.position) >= from) ? POS_W'(from + delta) : POS_W'(from - delta);
      p.last       = 1'b0;
      poses_expected.push_back(p);
    end
    p.step_index = STEP_W'(n);
    p.position   = kf.position;
    p.last       = 1'b1;
    poses_expected.push_back(p);
    last_keyframe[kf.channel] = kf.position;
  endfunction

  // compare one received pose against the oldest expected one
  function automatic void check_pose(input pose_t got);
    pose_t want;
    if (poses_expected.size() == 0) begin
      if (mismatches < 10)
        $display("unexpected pose: ch %0d idx %0d pos %0d last %0d",
                 got.channel, got.step_index, got.position, got.last);
      mismatches++;
      return;
    end
    want = poses_expected.pop_front();
    if (got.channel != want.channel || got.step_index != want.step_index ||
        got.position != want.position || got.last != want.last) begin
      if (mismatches < 10)
        $display("pose mismatch: expected ch %0d idx %0d pos %0d last %0d, got ch %0d idx %0d pos %0d last %0d",
                 want.channel, want.step_index, want.position, want.last,
                 got.channel, got.step_index, got.position, got.last);
      mismatches++;
    end
  endfunction

  // request driver
  keyframe_t in_flight;
  logic      presenting;
  int        send_gap;
  logic      send_burst;
  always @(posedge clk) begin
    if (rst) begin
      presenting = 1'b0;
      send_gap   = 0;
      send_burst = 1'b0;
      s_tvalid  <= 1'b0;
      s_tdata   <= '0;
    end else begin
      if (s_tvalid && s_tready) begin
        interpolate_keyframe(in_flight);
        keyframes_taken++;
        presenting = 1'b0;
        if (keyframes_taken % 32 == 0) send_burst = ($urandom_range(0, 2) == 0);
        send_gap = send_burst ? 0 : $urandom_range(0, 7);
      end
      if (!presenting) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (keyframes_pending.size() != 0) begin
          in_flight  = keyframes_pending.pop_front();
          presenting = 1'b1;
        end
      end
      s_tvalid <= presenting;
      s_tdata  <= {7'b0, in_flight.steps, in_flight.position, in_flight.channel};
    end
  end

  // result monitor with random backpressure
  pose_t got_pose;
  int    recv_stall;
  logic  recv_burst;
  always @(posedge clk) begin
    if (rst) begin
      recv_stall = 0;
      recv_burst = 1'b0;
      m_tready  <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got_pose.channel    = m_tdata[4:0];
        got_pose.step_index = m_tdata[8:5];
        got_pose.position   = m_tdata[24:9];
        got_pose.last       = m_tlast;
        check_pose(got_pose);
        poses_taken++;
        if (poses_taken % 40 == 0) recv_burst = ($urandom_range(0, 2) == 0);
        recv_stall = recv_burst ? 0 : $urandom_range(0, 7);
      end else if (recv_stall > 0) begin
        recv_stall--;
      end
      m_tready <= (recv_stall == 0);
    end
  end

  // watchdog on cycles with no handshake on either side
  int idle_cycles;
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles = 0;
    end else if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  task automatic queue_keyframe(input int ch, input int pos, input int steps);
    keyframe_t kf;
    kf.channel  = CH_W'(ch);
    kf.position = POS_W'(pos);
    kf.steps    = STEP_W'(steps);
    keyframes_pending.push_back(kf);
    keyframes_total++;
  endtask

  // stimulus and end of run
  initial begin
    int gen_last[32];
    int ch;
    int pos;
    int steps;
    int pick;
    foreach (channel_started[i]) channel_started[i] = 1'b0;
    foreach (gen_last[i]) gen_last[i] = 0;

    // directed: first keyframe, extremes, equal, zero steps, dropped channels
    queue_keyframe(0, 1000, 5);
    queue_keyframe(0, 65535, 15);
    queue_keyframe(0, 0, 15);
    queue_keyframe(0, 0, 3);
    queue_keyframe(0, 12345, 0);
    queue_keyframe(16, 65535, 0);
    queue_keyframe(16, 0, 7);
    queue_keyframe(17, 5, 2);
    queue_keyframe(31, 65535, 15);
    queue_keyframe(16, 1, 15);
    queue_keyframe(5, 0, 15);
    queue_keyframe(5, 7, 6);
    queue_keyframe(5, 32768, 1);
    queue_keyframe(0, 65535, 14);
    queue_keyframe(24, 0, 0);
    queue_keyframe(16, 65534, 1);
    gen_last[0] = 65535; gen_last[5] = 32768; gen_last[16] = 65534;

    // random keyframes, mostly on valid channels
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      ch = ($urandom_range(0, 99) < 12) ? $urandom_range(17, 31) : $urandom_range(0, 16);
      pick = $urandom_range(0, 9);
      case (pick)
        0:       pos = 0;
        1:       pos = 65535;
        2:       pos = gen_last[ch];
        3, 4:    pos = (gen_last[ch] + $urandom_range(0, 40) - 20) & 16'hffff;
        5:       pos = $urandom_range(0, 255);
        default: pos = $urandom_range(0, 65535);
      endcase
      steps = ($urandom_range(0, 9) == 0) ? 15 : $urandom_range(0, 15);
      gen_last[ch] = pos;
      queue_keyframe(ch, pos, steps);
    end

    do @(posedge clk); while (rst);
    while (keyframes_taken != keyframes_total || poses_expected.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && poses_expected.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // hold reset at the start of the run, then release it
  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
  end

endmodule

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/pki_pkg.sv
hw/rtl/pki_front.sv
hw/rtl/pki_queue.sv
hw/rtl/pki_back.sv
hw/rtl/pose_keyframe_interpolator_top.sv
hw/rtl/pki_checker.sv
dv/testbench.sv
